// File: rtl/gma_pkg.sv
// ----------------------------------------------------------------------------
// gma_pkg
// Shared types, widths and helpers of the grouped moving average block.
// ----------------------------------------------------------------------------
package gma_pkg;

  // Sizing
  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned PRICE_BITS = 16;
  localparam int unsigned DATE_W     = 16;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned NUM_GROUPS = 2;

  // Derived widths
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW + 1);       // window length, fill count
  localparam int unsigned SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned ADDR_W  = $clog2(NUM_GROUPS * MAX_WINDOW);
  localparam int unsigned DEPTH   = NUM_GROUPS * MAX_WINDOW;
  localparam int unsigned SUM_W   = PRICE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int unsigned STORE_W = 2 * PRICE_BITS;
  localparam int unsigned DCNT_W  = $clog2(SUM_W + 1);

  // Input word
  typedef struct packed {
    logic                  group;
    logic [DATE_W-1:0]     date_tag;
    logic [PRICE_BITS-1:0] price_a;
    logic [PRICE_BITS-1:0] price_b;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                  out_group;
    logic [DATE_W-1:0]     out_date;
    logic [PRICE_BITS-1:0] avg_a;
    logic [PRICE_BITS-1:0] avg_b;
  } out_word_t;

  // Divider request and status
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // Window length in use: zero reads as one, large values saturate
  function automatic logic [CNT_W-1:0] eff_length(input logic [CFG_W-1:0] cfg);
    logic [31:0] v;
    v = 32'(cfg);
    if (v == 32'd0) begin
      v = 32'd1;
    end
    if (v > 32'(MAX_WINDOW)) begin
      v = 32'(MAX_WINDOW);
    end
    return v[CNT_W-1:0];
  endfunction

endpackage

// File: rtl/grouped_moving_average.sv
// ----------------------------------------------------------------------------
// grouped_moving_average
// Per-group sliding-window averages of two prices over the last M records.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (group, date tag, two prices) arrive on in_valid_i/in_stall_o
//   in date order. Each group keeps its own window of the last M records.
//   Once a group holds M records, every record of that group yields one
//   result word on out_valid_o/out_stall_i: both window sums divided by M,
//   truncated, tagged with the record's group and date.
//   M is set through cfg_we_i/cfg_wdata_i while the block is idle; a write
//   clears sums, fill counts and write slots of both groups.
// Timing:
//   A record that yields no result passes through ST_UPDATE only. A record
//   that yields a result passes through ST_UPDATE, ST_DIV_A, ST_DIV_B and
//   ST_OUT, which loads its result word: the two divisions by M run one after
//   the other on the shared bit-serial divider, one quotient bit per cycle.
//   in_stall_o is high for the whole time a record is in work.
// Reset:
//   Sums, counts and slots clear, M returns to 1; the history RAM is not
//   cleared, its entries are only used once written.
// Stall:
//   A result waits in the output register while out_stall_i is high; the
//   next record is still accepted, and its result waits behind that one.
// ----------------------------------------------------------------------------
module grouped_moving_average (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gma_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gma_pkg::out_word_t          out_word_o,
  input  logic                        cfg_we_i,
  input  logic [gma_pkg::CFG_W-1:0]   cfg_wdata_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_DIV_A  = 5'b00100,
    ST_DIV_B  = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [gma_pkg::CFG_W-1:0]       cfg_q, cfg_d;
  logic [gma_pkg::SUM_W-1:0]       sum_a_q [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SUM_W-1:0]       sum_a_d [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SUM_W-1:0]       sum_b_q [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SUM_W-1:0]       sum_b_d [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::CNT_W-1:0]       fill_q  [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::CNT_W-1:0]       fill_d  [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SLOT_W-1:0]      slot_q  [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SLOT_W-1:0]      slot_d  [gma_pkg::NUM_GROUPS];
  gma_pkg::in_word_t               item_q, item_d;
  logic [gma_pkg::CNT_W-1:0]       sel_q, sel_d;
  logic [gma_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic [gma_pkg::PRICE_BITS-1:0]  avg_a_q, avg_a_d;
  gma_pkg::out_word_t              out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic                            accept;
  logic [gma_pkg::CNT_W-1:0]       m_len;
  logic [gma_pkg::CNT_W-1:0]       in_slot;
  logic [gma_pkg::ADDR_W-1:0]      in_addr;
  logic                            g;
  logic                            full_before;
  logic [gma_pkg::CNT_W-1:0]       fill_inc;
  logic [gma_pkg::CNT_W-1:0]       sel_inc;
  logic [gma_pkg::SUM_W-1:0]       old_a, old_b;
  logic [gma_pkg::SUM_W-1:0]       new_sum_a, new_sum_b;
  logic                            has_result;
  logic                            out_free;
  logic [gma_pkg::STORE_W-1:0]     ram_rdata;
  logic                            ram_we;
  gma_pkg::div_req_t               div_req;
  gma_pkg::div_rsp_t               div_rsp;

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Slot and address for an incoming word
  assign m_len   = gma_pkg::eff_length(cfg_q);
  assign in_slot = ({1'b0, slot_q[in_word_i.group]} >= m_len) ? '0
                 : gma_pkg::CNT_W'(slot_q[in_word_i.group]);
  assign in_addr = in_word_i.group
                 ? gma_pkg::ADDR_W'(gma_pkg::MAX_WINDOW) + gma_pkg::ADDR_W'(in_slot)
                 : gma_pkg::ADDR_W'(in_slot);

  // Window update terms
  assign g           = item_q.group;
  assign full_before = (fill_q[g] >= m_len);
  assign fill_inc    = fill_q[g] + gma_pkg::CNT_W'(1);
  assign sel_inc     = sel_q + gma_pkg::CNT_W'(1);
  assign old_a       = full_before ? gma_pkg::SUM_W'(ram_rdata[gma_pkg::PRICE_BITS-1:0]) : '0;
  assign old_b       = full_before
                     ? gma_pkg::SUM_W'(ram_rdata[gma_pkg::STORE_W-1:gma_pkg::PRICE_BITS]) : '0;
  assign new_sum_a   = sum_a_q[g] - old_a + gma_pkg::SUM_W'(item_q.price_a);
  assign new_sum_b   = sum_b_q[g] - old_b + gma_pkg::SUM_W'(item_q.price_b);
  assign has_result  = full_before || (fill_inc >= m_len);
  assign ram_we      = (state_q == ST_UPDATE);

  // Sequencer and state update
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    item_d      = item_q;
    sel_d       = sel_q;
    addr_d      = addr_q;
    avg_a_d     = avg_a_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req.start    = 1'b0;
    div_req.dividend = new_sum_a;
    div_req.divisor  = m_len;

    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          cfg_d = cfg_wdata_i;
          for (int i = 0; i < gma_pkg::NUM_GROUPS; i++) begin
            sum_a_d[i] = '0;
            sum_b_d[i] = '0;
            fill_d[i]  = '0;
            slot_d[i]  = '0;
          end
        end
        if (accept) begin
          item_d  = in_word_i;
          sel_d   = in_slot;
          addr_d  = in_addr;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        sum_a_d[g] = new_sum_a;
        sum_b_d[g] = new_sum_b;
        if (!full_before) begin
          fill_d[g] = fill_inc;
        end
        slot_d[g] = (sel_inc >= m_len) ? '0 : gma_pkg::SLOT_W'(sel_inc);
        if (has_result) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV_A;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_A: begin
        div_req.dividend = sum_b_q[g];
        if (div_rsp.done) begin
          avg_a_d       = div_rsp.quotient[gma_pkg::PRICE_BITS-1:0];
          div_req.start = 1'b1;
          state_d       = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // the divider holds its quotient until the output register frees up
        if (out_free) begin
          out_d.out_group = item_q.group;
          out_d.out_date  = item_q.date_tag;
          out_d.avg_a     = avg_a_q;
          out_d.avg_b     = div_rsp.quotient[gma_pkg::PRICE_BITS-1:0];
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= gma_pkg::CFG_W'(1);
      out_valid_q <= 1'b0;
      for (int i = 0; i < gma_pkg::NUM_GROUPS; i++) begin
        sum_a_q[i] <= '0;
        sum_b_q[i] <= '0;
        fill_q[i]  <= '0;
        slot_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    sel_q   <= sel_d;
    addr_q  <= addr_d;
    avg_a_q <= avg_a_d;
    out_q   <= out_d;
  end

  // Price history
  gma_window_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i ({item_q.price_b, item_q.price_a}),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Shared divider
  gma_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: rtl/gma_divider.sv
// ----------------------------------------------------------------------------
// gma_divider
// Restoring divider, one quotient bit per cycle, shared by both window sums.
// ----------------------------------------------------------------------------
module gma_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gma_pkg::div_req_t req_i,
  output gma_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [gma_pkg::DCNT_W-1:0]   cnt_q, cnt_d;
  logic [gma_pkg::SUM_W-1:0]    quo_q, quo_d;
  logic [gma_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [gma_pkg::CNT_W-1:0]    dvs_q, dvs_d;
  logic [gma_pkg::CNT_W:0]      trial;
  logic [gma_pkg::CNT_W:0]      diff;
  logic                         qbit;

  // One trial subtraction per cycle
  assign trial = {rem_q, quo_q[gma_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      quo_d = {quo_q[gma_pkg::SUM_W-2:0], qbit};
      rem_d = qbit ? diff[gma_pkg::CNT_W-1:0] : trial[gma_pkg::CNT_W-1:0];
      cnt_d = cnt_q - gma_pkg::DCNT_W'(1);
      if (cnt_q == gma_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = gma_pkg::DCNT_W'(gma_pkg::SUM_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/gma_window_ram.sv
// ----------------------------------------------------------------------------
// gma_window_ram
// Price history of both groups: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gma_window_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [gma_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [gma_pkg::STORE_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [gma_pkg::ADDR_W-1:0]   raddr_i,
  output logic [gma_pkg::STORE_W-1:0]  rdata_o
);

  logic [gma_pkg::STORE_W-1:0] mem_q [gma_pkg::DEPTH];
  logic [gma_pkg::STORE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/tb_grouped_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_moving_average
// Checks the per-group moving averages against a cycle-free predictor. Short
// directed tests cover price and date extremes, zero and short window
// lengths, and the history clear that a window write causes. A receiver
// hold-off fills the block until it stalls its input. Random phases then run
// many window lengths, saturating ones among them, with random gaps on both
// sides of the block, except in every third phase.
// ----------------------------------------------------------------------------
module tb_grouped_moving_average;

  localparam int SETTLE_CYCLES = 60;  // longer than one record in work

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  gma_pkg::in_word_t           in_word_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  gma_pkg::out_word_t          out_word_o;
  logic                        cfg_we_i    = 1'b0;
  logic [gma_pkg::CFG_W-1:0]   cfg_wdata_i = '0;

  // Window history and sums as the block should hold them
  logic [gma_pkg::CFG_W-1:0]      win_cfg;
  logic [gma_pkg::PRICE_BITS-1:0] hist_a [gma_pkg::NUM_GROUPS][gma_pkg::MAX_WINDOW];
  logic [gma_pkg::PRICE_BITS-1:0] hist_b [gma_pkg::NUM_GROUPS][gma_pkg::MAX_WINDOW];
  logic [gma_pkg::SUM_W-1:0]      sum_a  [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SUM_W-1:0]      sum_b  [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::CNT_W-1:0]      fill   [gma_pkg::NUM_GROUPS];
  logic [gma_pkg::SLOT_W-1:0]     slot   [gma_pkg::NUM_GROUPS];

  gma_pkg::out_word_t pending_avgs [$];
  int        fail_count  = 0;
  int        hold_cycles = 0;
  bit        tx_idle_en  = 1'b1;
  bit        rx_idle_en  = 1'b1;
  logic [gma_pkg::DATE_W-1:0] date_seq = '0;
  logic                       last_group = 1'b0;

  always #5 clk_i = ~clk_i;

  grouped_moving_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // zero counts as one, long windows saturate
  function automatic int window_in_use();
    int m;
    m = int'(win_cfg);
    if (m == 0) m = 1;
    if (m > int'(gma_pkg::MAX_WINDOW)) m = int'(gma_pkg::MAX_WINDOW);
    return m;
  endfunction

  function automatic void clear_history();
    for (int g = 0; g < int'(gma_pkg::NUM_GROUPS); g++) begin
      sum_a[g] = '0;
      sum_b[g] = '0;
      fill[g]  = '0;
      slot[g]  = '0;
    end
  endfunction

  // Advances the group's window by one record; returns 1 when it yields a word
  function automatic bit average_record(input gma_pkg::in_word_t rec,
                                        output gma_pkg::out_word_t res);
    int g;
    int m;
    int s;
    g   = int'(rec.group);
    m   = window_in_use();
    s   = int'(slot[g]);
    res = '0;
    if (s >= m) s = 0;
    // full window: the slot holds the oldest record, drop it from the sums
    if (int'(fill[g]) >= m) begin
      sum_a[g] = sum_a[g] - gma_pkg::SUM_W'(hist_a[g][s]);
      sum_b[g] = sum_b[g] - gma_pkg::SUM_W'(hist_b[g][s]);
    end else begin
      fill[g] = fill[g] + 1'b1;
    end
    hist_a[g][s] = rec.price_a;
    hist_b[g][s] = rec.price_b;
    sum_a[g] = sum_a[g] + gma_pkg::SUM_W'(rec.price_a);
    sum_b[g] = sum_b[g] + gma_pkg::SUM_W'(rec.price_b);
    s = s + 1;
    if (s >= m) s = 0;
    slot[g] = gma_pkg::SLOT_W'(s);
    if (int'(fill[g]) < m) return 1'b0;
    res.out_group = rec.group;
    res.out_date  = rec.date_tag;
    res.avg_a     = gma_pkg::PRICE_BITS'(sum_a[g] / gma_pkg::SUM_W'(m));
    res.avg_b     = gma_pkg::PRICE_BITS'(sum_b[g] / gma_pkg::SUM_W'(m));
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, what);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  // biased toward the price extremes
  function automatic logic [gma_pkg::PRICE_BITS-1:0] pick_price();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return gma_pkg::PRICE_BITS'($urandom);
    endcase
  endfunction

  // Random record: dates mostly rising, sometimes out of order
  function automatic gma_pkg::in_word_t make_record();
    gma_pkg::in_word_t w;
    if ($urandom_range(0, 3) != 0) last_group = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) begin
      w.date_tag = gma_pkg::DATE_W'($urandom);
    end else begin
      date_seq   = date_seq + gma_pkg::DATE_W'($urandom_range(0, 3));
      w.date_tag = date_seq;
    end
    w.group   = last_group;
    w.price_a = pick_price();
    w.price_b = pick_price();
    return w;
  endfunction

  function automatic gma_pkg::in_word_t rec(logic grp, logic [15:0] date,
                                            logic [15:0] pa, logic [15:0] pb);
    gma_pkg::in_word_t w;
    w.group    = grp;
    w.date_tag = gma_pkg::DATE_W'(date);
    w.price_a  = gma_pkg::PRICE_BITS'(pa);
    w.price_b  = gma_pkg::PRICE_BITS'(pb);
    return w;
  endfunction

  // Offers one record and returns at the edge that takes it. Entered at an edge.
  task automatic send_record(input gma_pkg::in_word_t w);
    int                 gap;
    gma_pkg::out_word_t res;
    gap = (tx_idle_en && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (average_record(w, res)) pending_avgs.push_back(res);
  endtask

  // Drops valid, waits for every pending word, then lets the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [gma_pkg::CFG_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_cfg = len;
    clear_history();
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall runs, plus a hold-off counted down here
  // --------------------------------------------------------------------------
  initial begin : rx_throttle
    int run_len;
    run_len = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (run_len > 0) begin
        out_stall_i <= 1'b1;
        run_len--;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_idle_en && $urandom_range(0, 3) == 0) run_len = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest pending word
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    gma_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_avgs.size() == 0) begin
        note_failure($sformatf("unexpected word %p", out_word_o));
      end else begin
        exp_w = pending_avgs.pop_front();
        if (out_word_o.out_group !== exp_w.out_group ||
            out_word_o.out_date  !== exp_w.out_date  ||
            out_word_o.avg_a     !== exp_w.avg_a     ||
            out_word_o.avg_b     !== exp_w.avg_b) begin
          note_failure($sformatf(
            "exp grp %0d date %h a %h b %h, got grp %0d date %h a %h b %h",
            exp_w.out_group, exp_w.out_date, exp_w.avg_a, exp_w.avg_b,
            out_word_o.out_group, out_word_o.out_date,
            out_word_o.avg_a, out_word_o.avg_b));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Window of one after reset: each record averages to itself
  task automatic test_reset_window();
    send_record(rec(1'b1, 16'h0000, 16'h0000, 16'h0000));
    send_record(rec(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_record(rec(1'b1, 16'h8000, 16'hFFFF, 16'h0000));
    send_record(rec(1'b0, 16'h0001, 16'h0000, 16'hFFFF));
    send_record(rec(1'b1, 16'h5555, 16'hAAAA, 16'h5555));
    send_record(rec(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA));
    wait_idle();
  endtask

  // Length zero behaves as one
  task automatic test_zero_length();
    set_window('0);
    send_record(rec(1'b0, 16'h0010, 16'h1234, 16'hFEDC));
    send_record(rec(1'b1, 16'h0011, 16'hFFFF, 16'h0001));
    send_record(rec(1'b0, 16'h0012, 16'h0001, 16'hFFFF));
    wait_idle();
  endtask

  // Short window, interleaved groups, full-scale sums, dates out of order
  task automatic test_short_window();
    set_window(gma_pkg::CFG_W'(3));
    send_record(rec(1'b1, 16'h0100, 16'hFFFF, 16'hFFFF));
    send_record(rec(1'b0, 16'h0101, 16'h0001, 16'h0002));
    send_record(rec(1'b1, 16'h0102, 16'hFFFF, 16'hFFFF));
    send_record(rec(1'b1, 16'h0050, 16'hFFFF, 16'hFFFE));
    send_record(rec(1'b0, 16'h0103, 16'h0004, 16'h0000));
    send_record(rec(1'b1, 16'h0104, 16'h0000, 16'h0000));
    send_record(rec(1'b0, 16'hFFFF, 16'hFFFF, 16'h0007));
    send_record(rec(1'b0, 16'h0000, 16'h8000, 16'h7FFF));
    wait_idle();
  endtask

  // A window write drops the history, shown here for group 1
  task automatic test_history_clear();
    set_window(gma_pkg::CFG_W'(2));
    send_record(rec(1'b1, 16'h0200, 16'h1111, 16'h2222));
    wait_idle();
    set_window(gma_pkg::CFG_W'(2));
    send_record(rec(1'b1, 16'h0201, 16'h3333, 16'h4444));
    send_record(rec(1'b1, 16'h0202, 16'h5555, 16'h6666));
    wait_idle();
  endtask

  // Receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_window(gma_pkg::CFG_W'(1));
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) send_record(make_record());
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Random records under many window lengths, saturating ones included
  task automatic test_random_windows();
    int lens   [10] = '{64, 5, 127, 1, 0, 2, 30, 65, 9, 0};
    int counts [10] = '{140, 60, 140, 60, 40, 60, 100, 100, 60, 60};
    lens[9] = $urandom_range(1, 127);
    for (int p = 0; p < 10; p++) begin
      tx_idle_en = (p % 3 != 1);
      rx_idle_en = (p % 3 != 1);
      set_window(gma_pkg::CFG_W'(lens[p]));
      for (int i = 0; i < counts[p]; i++) send_record(make_record());
      wait_idle();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    win_cfg = gma_pkg::CFG_W'(1);
    clear_history();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_window();
    test_zero_length();
    test_short_window();
    test_history_clear();
    test_backpressure();
    test_random_windows();
    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin : run_limit
    #(20_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/gma_pkg.sv
rtl/gma_divider.sv
rtl/gma_window_ram.sv
rtl/grouped_moving_average.sv
tb/tb_grouped_moving_average.sv
